// ===== hw/rtl/ctbe_pkg.sv =====
// Shared constants, command and status codes, and control structs for the text buffer editor.
package ctbe_pkg;

    localparam int CAPACITY_DEF = 4096;

    localparam int CMD_W  = 3;
    localparam int CH_W   = 8;
    localparam int IDX_W  = 12;
    localparam int TEXT_W = 13;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctbe_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } ctbe_stat_t;

endpackage

// ===== hw/rtl/ctbe_if.sv =====
// Request and response channel interfaces for the text buffer editor.
interface ctbe_req_if
    import ctbe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CH_W-1:0]   ch;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, output cmd, output ch, output read_index, input ready);
    modport sink   (input valid, input cmd, input ch, input read_index, output ready);
endinterface

interface ctbe_rsp_if
    import ctbe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_length;
    logic [TEXT_W-1:0] cursor_pos;
    logic [CH_W-1:0]   read_char;
    logic [ST_W-1:0]   status;

    modport source (output valid, output text_length, output cursor_pos, output read_char,
                    output status, input ready);
    modport sink   (input valid, input text_length, input cursor_pos, input read_char,
                    input status, output ready);
endinterface

// ===== hw/rtl/ctbe_ctrl.sv =====
// Command sequencer: accepts a request, then commits it once the result register is free.
module ctbe_ctrl
    import ctbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ctbe_stat_t stat,
    output ctbe_ctl_t  ctl
);

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        req_ready   = (state_reg == IDLE);
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = EXEC;
                end
            end
            EXEC:
            begin
                // wait while the previous result is still unclaimed
                if (!stat.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ctbe_datapath.sv =====
// Gap buffer datapath: left and right stacks, counts, and the result register.
module ctbe_datapath
    import ctbe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctbe_ctl_t         ctl,
    output ctbe_stat_t        stat,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [CH_W-1:0]   ch,
    input  logic [IDX_W-1:0]  read_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TEXT_W-1:0] text_length,
    output logic [TEXT_W-1:0] cursor_pos,
    output logic [CH_W-1:0]   read_char,
    output logic [ST_W-1:0]   status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CH_W-1:0] left_mem  [CAPACITY];
    logic [CH_W-1:0] right_mem [CAPACITY];

    logic [CW-1:0]     left_cnt_reg, left_cnt_next;
    logic [CW-1:0]     right_cnt_reg, right_cnt_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CH_W-1:0]   left_rd_reg;
    logic [CH_W-1:0]   right_rd_reg;
    logic              out_valid_reg;
    logic [TEXT_W-1:0] text_length_reg;
    logic [TEXT_W-1:0] cursor_pos_reg;
    logic [CH_W-1:0]   read_char_reg;
    logic [ST_W-1:0]   status_reg;

    logic [CW-1:0]   total;
    logic [CW-1:0]   total_next;
    logic [XW-1:0]   idx_in_x;
    logic [XW-1:0]   total_x;
    logic [AW-1:0]   left_ra;
    logic [AW-1:0]   right_ra;
    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   left_x;
    logic            left_we;
    logic            right_we;
    logic [AW-1:0]   left_wa;
    logic [AW-1:0]   right_wa;
    logic [CH_W-1:0] left_wd;
    logic [CH_W-1:0] right_wd;
    logic [CH_W-1:0] rd_char;
    logic [ST_W-1:0] st;

    assign total    = left_cnt_reg + right_cnt_reg;
    assign idx_in_x = XW'(read_index);
    assign total_x  = XW'(total);
    assign idx_x    = XW'(idx_reg);
    assign left_x   = XW'(left_cnt_reg);

    // read addresses are formed from the incoming request; both stacks are read
    always_comb
    begin
        if (cmd == CMD_READ)
        begin
            left_ra  = AW'(read_index);
            // right stack is reversed: text position p sits at total-1-p
            right_ra = AW'(total_x - XW'(1) - idx_in_x);
        end
        else
        begin
            left_ra  = AW'(left_cnt_reg - CW'(1));
            right_ra = AW'(right_cnt_reg - CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg      <= cmd;
            ch_reg       <= ch;
            idx_reg      <= read_index;
            left_rd_reg  <= left_mem[left_ra];
            right_rd_reg <= right_mem[right_ra];
        end
    end

    always_comb
    begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        left_we        = 1'b0;
        right_we       = 1'b0;
        left_wa        = AW'(left_cnt_reg);
        right_wa       = AW'(right_cnt_reg);
        left_wd        = right_rd_reg;
        right_wd       = left_rd_reg;
        rd_char        = '0;
        st             = ST_OK;
        unique case (cmd_reg)
            CMD_LEFT:
            begin
                if ((left_cnt_reg != '0) && (right_cnt_reg < CAP_C))
                begin
                    left_cnt_next  = left_cnt_reg - CW'(1);
                    right_cnt_next = right_cnt_reg + CW'(1);
                    right_we       = 1'b1;
                end
            end
            CMD_RIGHT:
            begin
                if ((right_cnt_reg != '0) && (left_cnt_reg < CAP_C))
                begin
                    right_cnt_next = right_cnt_reg - CW'(1);
                    left_cnt_next  = left_cnt_reg + CW'(1);
                    left_we        = 1'b1;
                end
            end
            CMD_BACK:
            begin
                if (left_cnt_reg != '0)
                begin
                    left_cnt_next = left_cnt_reg - CW'(1);
                end
            end
            CMD_INSERT:
            begin
                if ((total >= CAP_C) || (left_cnt_reg >= CAP_C))
                begin
                    st = ST_FULL;
                end
                else
                begin
                    left_cnt_next = left_cnt_reg + CW'(1);
                    left_we       = 1'b1;
                    left_wd       = ch_reg;
                end
            end
            CMD_READ:
            begin
                if (idx_x >= total_x)
                begin
                    st = ST_RANGE;
                end
                else if (idx_x < left_x)
                begin
                    rd_char = left_rd_reg;
                end
                else
                begin
                    rd_char = right_rd_reg;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign total_next = left_cnt_next + right_cnt_next;

    always_ff @(posedge clk)
    begin
        if (ctl.commit && left_we)
        begin
            left_mem[left_wa] <= left_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && right_we)
        begin
            right_mem[right_wa] <= right_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                left_cnt_reg  <= left_cnt_next;
                right_cnt_reg <= right_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            text_length_reg <= TEXT_W'(total_next);
            cursor_pos_reg  <= TEXT_W'(left_cnt_next);
            read_char_reg   <= rd_char;
            status_reg      <= st;
        end
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign text_length   = text_length_reg;
    assign cursor_pos    = cursor_pos_reg;
    assign read_char     = read_char_reg;
    assign status        = status_reg;

endmodule

// ===== hw/rtl/cursor_text_buffer_editor_top.sv =====
// A request is accepted in IDLE, where both stacks are read (registered read); in EXEC the
// moved or inserted byte is written and the response register loaded, once the result
// register is free. A new request is not accepted until the previous one has committed.
// A held response stalls only the commit of the next request, not its acceptance.
// Reset clears the counts and handshake state; the stacks are not cleared.
// Top level of the cursor text buffer editor.
module cursor_text_buffer_editor_top
    import ctbe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    ctbe_req_if.sink    req,
    ctbe_rsp_if.source  rsp
);

    ctbe_ctl_t  ctl;
    ctbe_stat_t stat;
    logic       req_ready;

    assign req.ready = req_ready;

    ctbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    ctbe_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (req.cmd),
        .ch          (req.ch),
        .read_index  (req.read_index),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .text_length (rsp.text_length),
        .cursor_pos  (rsp.cursor_pos),
        .read_char   (rsp.read_char),
        .status      (rsp.status)
    );

endmodule

// ===== verif/tb_cursor_text_buffer_editor_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cursor text buffer editor (directed table and random edits).
module tb_cursor_text_buffer_editor_top;
    import ctbe_pkg::*;

    localparam int TEXT_CAP    = CAPACITY_DEF;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_EDITS  = 1275;
    localparam int CYCLE_LIMIT = 1000000;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

    localparam logic [CH_W-1:0] CH_L = "L";
    localparam logic [CH_W-1:0] CH_D = "D";
    localparam logic [CH_W-1:0] CH_B = "B";
    localparam logic [CH_W-1:0] CH_P = "P";

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  ch;
        logic [IDX_W-1:0] idx;
    } edit_req_t;

    typedef struct packed {
        logic [TEXT_W-1:0] len;
        logic [TEXT_W-1:0] cur;
        logic [CH_W-1:0]   rd;
        logic [ST_W-1:0]   st;
    } edit_rsp_t;

    typedef struct packed {
        edit_req_t rq;
        bit        typed;
        edit_rsp_t rs;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ctbe_req_if req_ch();
    ctbe_rsp_if rsp_ch();

    cursor_text_buffer_editor_top #(
        .CAPACITY(TEXT_CAP)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow gap buffer
    logic [CH_W-1:0] left_mem  [0:TEXT_CAP-1];
    logic [CH_W-1:0] right_mem [0:TEXT_CAP-1];
    int unsigned     left_cnt  = 0;
    int unsigned     right_cnt = 0;

    edit_rsp_t   pending_rsp_q[$];
    dir_row_t    dir_tab [DIR_ROWS];
    idle_mode_t  idle_mode = IDLE_NONE;
    int unsigned req_cnt   = 0;
    int unsigned rsp_cnt   = 0;
    int unsigned fail_cnt  = 0;
    int unsigned full_cnt  = 0;
    int unsigned range_cnt = 0;
    int unsigned peak_len  = 0;
    int unsigned cycle_cnt = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic edit_rsp_t apply_edit(edit_req_t rq);
        edit_rsp_t   rs;
        int unsigned total;
        int unsigned depth;
        rs    = '0;
        rs.st = ST_OK;
        total = left_cnt + right_cnt;
        case (rq.cmd)
            CMD_LEFT:
                if (left_cnt > 0 && right_cnt < TEXT_CAP)
                begin
                    left_cnt--;
                    right_mem[right_cnt] = left_mem[left_cnt];
                    right_cnt++;
                end
            CMD_RIGHT:
                if (right_cnt > 0 && left_cnt < TEXT_CAP)
                begin
                    right_cnt--;
                    left_mem[left_cnt] = right_mem[right_cnt];
                    left_cnt++;
                end
            CMD_BACK:
                if (left_cnt > 0)
                    left_cnt--;
            CMD_INSERT:
                if (total >= TEXT_CAP || left_cnt >= TEXT_CAP)
                    rs.st = ST_FULL;
                else
                begin
                    left_mem[left_cnt] = rq.ch;
                    left_cnt++;
                end
            CMD_READ:
                if (rq.idx >= total)
                    rs.st = ST_RANGE;
                else if (rq.idx < left_cnt)
                    rs.rd = left_mem[rq.idx];
                else
                begin
                    // right stack is stored top-down from the cursor
                    depth = rq.idx - left_cnt;
                    rs.rd = right_mem[right_cnt - 1 - depth];
                end
            default: ;
        endcase
        rs.len = TEXT_W'(left_cnt + right_cnt);
        rs.cur = TEXT_W'(left_cnt);
        return rs;
    endfunction

    function automatic dir_row_t mk_row(logic [CMD_W-1:0] c, logic [CH_W-1:0] b,
                                        logic [IDX_W-1:0] i, bit t, int len, int cur,
                                        logic [CH_W-1:0] rd, logic [ST_W-1:0] st);
        dir_row_t r;
        r.rq    = '{cmd: c, ch: b, idx: i};
        r.typed = t;
        r.rs    = '{len: TEXT_W'(len), cur: TEXT_W'(cur), rd: rd, st: st};
        return r;
    endfunction

    // random edit shaped by the current text length; reads mostly land in range
    function automatic edit_req_t pick_edit();
        edit_req_t   rq;
        int unsigned r;
        int unsigned total;
        int unsigned grow;
        total  = left_cnt + right_cnt;
        rq.ch  = CH_W'($urandom_range(0, 255));
        rq.idx = IDX_W'($urandom_range(0, 4095));
        grow   = (total < 64) ? 40 : ((total > 400) ? 15 : 28);
        r      = $urandom_range(0, 99);
        if (r < grow)
            rq.cmd = CMD_INSERT;
        else if (r < grow + 15)
            rq.cmd = CMD_LEFT;
        else if (r < grow + 30)
            rq.cmd = CMD_RIGHT;
        else if (r < grow + 40)
            rq.cmd = CMD_BACK;
        else if (r < 96)
        begin
            rq.cmd = CMD_READ;
            if (total > 0 && $urandom_range(0, 9) != 0)
                rq.idx = IDX_W'($urandom_range(0, total - 1));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       rq.cmd = CMD_RSV5;
                1:       rq.cmd = CMD_RSV6;
                default: rq.cmd = CMD_RSV7;
            endcase
        end
        return rq;
    endfunction

    task automatic send_edit(input edit_req_t rq, input bit typed, input edit_rsp_t typed_rs);
        edit_rsp_t   rs;
        int unsigned gap_pct;
        idle_mode = idle_mode_t'((req_cnt / 160) % 4);
        gap_pct   = (idle_mode == IDLE_SEND) ? 55 : ((idle_mode == IDLE_BOTH) ? 7 : 0);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= rq.cmd;
        req_ch.ch         <= rq.ch;
        req_ch.read_index <= rq.idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        rs = apply_edit(rq);
        pending_rsp_q.insert(pending_rsp_q.size(), typed ? typed_rs : rs);
        req_cnt++;
        if (rs.st == ST_FULL)
            full_cnt++;
        if (rs.st == ST_RANGE)
            range_cnt++;
        if (rs.len > peak_len)
            peak_len = rs.len;
    endtask

    // response side stalls
    always @(negedge clk)
    begin : rsp_stall
        int unsigned stall_pct;
        stall_pct = (idle_mode == IDLE_RECV) ? 55 : ((idle_mode == IDLE_BOTH) ? 7 : 0);
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : rsp_check
        edit_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_cnt++;
            if (pending_rsp_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: response with nothing pending (len %0d cur %0d rd %0h st %0d)",
                         $time, rsp_ch.text_length, rsp_ch.cursor_pos, rsp_ch.read_char,
                         rsp_ch.status);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp_ch.text_length !== want.len)
                begin
                    fail_cnt++;
                    $display("%0t: text_length expected %0d actual %0d",
                             $time, want.len, rsp_ch.text_length);
                end
                if (rsp_ch.cursor_pos !== want.cur)
                begin
                    fail_cnt++;
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $time, want.cur, rsp_ch.cursor_pos);
                end
                if (rsp_ch.read_char !== want.rd)
                begin
                    fail_cnt++;
                    $display("%0t: read_char expected %02h actual %02h",
                             $time, want.rd, rsp_ch.read_char);
                end
                if (rsp_ch.status !== want.st)
                begin
                    fail_cnt++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, rsp_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_cnt, pending_rsp_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int unsigned k;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_LEFT;
        req_ch.ch         = '0;
        req_ch.read_index = '0;
        rsp_ch.ready      = 1'b0;

        dir_tab = '{
            mk_row(CMD_LEFT,   8'h00, 12'd0,    1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_RIGHT,  8'h00, 12'd0,    1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_BACK,   8'h00, 12'd0,    1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd0,    1, 0, 0, 8'h00, ST_RANGE),
            mk_row(CMD_READ,   8'hFF, 12'hFFF,  1, 0, 0, 8'h00, ST_RANGE),
            mk_row(CMD_RSV5,   8'hFF, 12'hFFF,  1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_RSV6,   8'hFF, 12'hFFF,  1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_RSV7,   8'hFF, 12'hFFF,  1, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_INSERT, 8'h00, 12'hFFF,  1, 1, 1, 8'h00, ST_OK),
            mk_row(CMD_INSERT, 8'hFF, 12'd0,    1, 2, 2, 8'h00, ST_OK),
            mk_row(CMD_INSERT, CH_L,  12'd0,    1, 3, 3, 8'h00, ST_OK),
            mk_row(CMD_INSERT, CH_D,  12'd0,    1, 4, 4, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd0,    1, 4, 4, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd1,    1, 4, 4, 8'hFF, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd4,    1, 4, 4, 8'h00, ST_RANGE),
            mk_row(CMD_LEFT,   8'h00, 12'd0,    1, 4, 3, 8'h00, ST_OK),
            mk_row(CMD_LEFT,   8'h00, 12'd0,    1, 4, 2, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd2,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd3,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_INSERT, CH_B,  12'd0,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_RIGHT,  8'h00, 12'd0,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_BACK,   8'h00, 12'd0,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_INSERT, CH_P,  12'd0,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_READ,   8'h00, 12'd0,    0, 0, 0, 8'h00, ST_OK),
            mk_row(CMD_RSV7,   8'h5A, 12'hA5A,  0, 0, 0, 8'h00, ST_OK)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_edit(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].rs);

        for (k = 0; k < RAND_EDITS; k++)
            send_edit(pick_edit(), 1'b0, '0);

        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests sent, %0d responses checked, peak text length %0d of %0d",
                 req_cnt, rsp_cnt, peak_len, TEXT_CAP);
        $display("%0d inserts dropped on a full buffer, %0d out-of-range reads, %0d mismatches",
                 full_cnt, range_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ctbe_pkg.sv
hw/rtl/ctbe_if.sv
hw/rtl/ctbe_ctrl.sv
hw/rtl/ctbe_datapath.sv
hw/rtl/cursor_text_buffer_editor_top.sv
verif/tb_cursor_text_buffer_editor_top.sv
